/* rtl/core/cq_pkg.sv */
// Package for the circular queue: widths, command and status codes, and the
// command word passed from the front end to the execution back end.
// No dependencies.
`timescale 1ns / 1ps

package cq_pkg;

    // Default ring depth and data width
    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;

    // Command codes on the command port
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    // Decoded operation held in the command queue
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DUMP = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } back_state_t;

    // One queued command word
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] value;
    } cq_item_t;

    // Command queue status seen by the front and back ends
    typedef struct packed {
        logic valid;
        logic full;
    } cq_qstat_t;

endpackage

/* rtl/core/cq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/cq_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
// Depends on cq_pkg.
`timescale 1ns / 1ps

module cq_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  cq_pkg::cq_item_t wr_item,
    input  logic             rd_en,
    output cq_pkg::cq_item_t rd_item,
    output cq_pkg::cq_qstat_t qstat
);

    import cq_pkg::*;

    cq_item_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item     = slot_reg[rd_ptr_reg];
    assign qstat.valid = (cnt_reg != 2'd0);
    assign qstat.full  = (cnt_reg == 2'd2);

endmodule

/* rtl/core/cq_front.sv */
// Front end: takes commands, decodes them and drops the unused code.
// Depends on cq_pkg.
`timescale 1ns / 1ps

module cq_front (
    input  logic              start,
    input  logic [1:0]        command,
    input  logic [cq_pkg::WORD_W-1:0] push_value,
    input  cq_pkg::cq_qstat_t qstat,
    output logic              busy,
    output logic              wr_en,
    output cq_pkg::cq_item_t  wr_item
);

    import cq_pkg::*;

    logic cmd_ok;

    // Decode command into a queue word
    always_comb
    begin
        cmd_ok        = 1'b1;
        wr_item.value = push_value;
        case (command)
            CMD_PUSH: wr_item.op = OP_PUSH;
            CMD_POP:  wr_item.op = OP_POP;
            CMD_DUMP: wr_item.op = OP_DUMP;
            default:
            begin
                wr_item.op = OP_PUSH;
                cmd_ok     = 1'b0;
            end
        endcase
    end

    // Accept whenever the command queue has room
    assign busy  = qstat.full;
    assign wr_en = start && !qstat.full && cmd_ok;

endmodule

/* rtl/core/cq_back.sv */
// Back end: executes queued commands against the ring and drives results.
// Depends on cq_pkg and cq_ram.
`timescale 1ns / 1ps

module cq_back #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cq_pkg::cq_item_t  rd_item,
    input  cq_pkg::cq_qstat_t qstat,
    output logic              rd_en,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic signed [cq_pkg::WORD_W-1:0] data_value,
    output logic              last_flag
);

    import cq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic               res_valid_reg, res_valid_next;
    status_t            res_status_reg, res_status_next;
    logic [WORD_W-1:0]  res_data_reg, res_data_next;
    logic               res_last_reg, res_last_next;

    logic               dispatch;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    // Ring storage
    cq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (rd_item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a new command only when idle and no read is in flight
    assign dispatch = (state_reg == BK_IDLE) && !rd_pend_reg && qstat.valid;
    assign rd_en    = dispatch;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (dispatch && rd_item.op == OP_DUMP && count_reg != '0)
                begin
                    state_next = BK_DUMP;
                end
            end
            BK_DUMP:
            begin
                if (remain_reg == CNT_ONE)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        remain_next     = remain_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = 1'b0;
        ram_we          = 1'b0;
        ram_raddr       = head_reg;
        res_valid_next  = 1'b0;
        res_status_next = ST_OK;
        res_data_next   = '0;
        res_last_next   = 1'b1;

        // Read data returning from the ring
        if (rd_pend_reg)
        begin
            res_valid_next = 1'b1;
            res_data_next  = ram_rdata;
            res_last_next  = rd_last_reg;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (dispatch)
                begin
                    case (rd_item.op)
                        OP_PUSH:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = next_idx(tail_reg);
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_pend_next = 1'b1;
                                rd_last_next = 1'b1;
                                head_next    = next_idx(head_reg);
                                count_next   = count_reg - CNT_ONE;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pos_next    = head_reg;
                                remain_next = count_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_DUMP:
            begin
                // Stream one entry per cycle from oldest to newest
                ram_raddr    = pos_reg;
                rd_pend_next = 1'b1;
                rd_last_next = (remain_reg == CNT_ONE);
                pos_next     = next_idx(pos_reg);
                remain_next  = remain_reg - CNT_ONE;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign data_value   = res_data_reg;
    assign last_flag    = res_last_reg;

endmodule

/* rtl/core/circular_queue.sv */
// Circular FIFO queue of 32-bit words, top level. Push and full/empty results
// pass through the command queue and the result register; pop data and dump
// words also pass the registered ring RAM read, a dump first its dump state.
// Pushes sustain 1 per cycle while busy is low; a dump holds the back end until
// its last word is read, and the back end holds dispatch while a ring read is
// in flight. Results are one-cycle strobes with no backpressure. Reset empties
// the queue; ring contents are undefined until written.
// Depends on cq_pkg, cq_front, cq_cmd_fifo, cq_back, cq_ram.
`timescale 1ns / 1ps

module circular_queue #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic signed [cq_pkg::WORD_W-1:0] push_value,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic signed [cq_pkg::WORD_W-1:0] data_value,
    output logic        last_flag
);

    import cq_pkg::*;

    cq_qstat_t qstat;
    cq_item_t  wr_item;
    cq_item_t  rd_item;
    logic      wr_en;
    logic      rd_en;

    // Command decode and acceptance
    cq_front u_front (
        .start      (start),
        .command    (command),
        .push_value (push_value),
        .qstat      (qstat),
        .busy       (busy),
        .wr_en      (wr_en),
        .wr_item    (wr_item)
    );

    // Decoupling queue
    cq_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_item (wr_item),
        .rd_en   (rd_en),
        .rd_item (rd_item),
        .qstat   (qstat)
    );

    // Execution against the ring
    cq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_item      (rd_item),
        .qstat        (qstat),
        .rd_en        (rd_en),
        .result_valid (result_valid),
        .status       (status),
        .data_value   (data_value),
        .last_flag    (last_flag)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for circular_queue: directed and random push, pop
// and dump commands, checked against a shadow copy of the ring kept in a class.
// Depends on cq_pkg and the circular_queue RTL.
`timescale 1ns / 1ps

module tb_top;
    import cq_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 100;
    // Command code the block ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct {
        status_t st;
        word_t   data;
        logic    last;
    } cq_result_t;

    // Shadow ring: predicts the results of each accepted word and checks them
    class cq_shadow;
        word_t      ring [RING_DEPTH];
        int         head;
        int         tail;
        int         fill;
        cq_result_t due_results [$];
        int         faults;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            faults = 0;
        endfunction

        function void log_command(logic [1:0] cmd, word_t val);
            int pos;
            case (cmd)
                CMD_PUSH:
                begin
                    if (fill == RING_DEPTH)
                    begin
                        due_results.push_back('{st: ST_FULL, data: '0, last: 1'b1});
                    end
                    else
                    begin
                        ring[tail] = val;
                        tail = (tail == RING_DEPTH - 1) ? 0 : tail + 1;
                        fill++;
                        due_results.push_back('{st: ST_OK, data: '0, last: 1'b1});
                    end
                end
                CMD_POP:
                begin
                    if (fill == 0)
                    begin
                        due_results.push_back('{st: ST_EMPTY, data: '0, last: 1'b1});
                    end
                    else
                    begin
                        due_results.push_back('{st: ST_OK, data: ring[head], last: 1'b1});
                        head = (head == RING_DEPTH - 1) ? 0 : head + 1;
                        fill--;
                    end
                end
                CMD_DUMP:
                begin
                    if (fill == 0)
                    begin
                        due_results.push_back('{st: ST_EMPTY, data: '0, last: 1'b1});
                    end
                    else
                    begin
                        pos = head;
                        for (int i = 0; i < fill; i++)
                        begin
                            due_results.push_back('{st: ST_OK, data: ring[pos],
                                                    last: (i == fill - 1)});
                            pos = (pos == RING_DEPTH - 1) ? 0 : pos + 1;
                        end
                    end
                end
                default:
                begin
                    // unused code: no result, no state change
                end
            endcase
        endfunction

        function void flag_fault(string what);
            faults++;
            if (faults <= 10)
                $display("tb: mismatch at %0t: %s", $time, what);
        endfunction

        function void match_result(logic [1:0] st, word_t d, logic lf);
            cq_result_t want;
            if (due_results.size() == 0)
            begin
                flag_fault($sformatf("unexpected word status=%0d data=%0d last=%0d",
                                     st, d, lf));
                return;
            end
            want = due_results.pop_front();
            if (st !== want.st || d !== want.data || lf !== want.last)
                flag_fault($sformatf("exp status=%0d data=%0d last=%0d, got status=%0d data=%0d last=%0d",
                                     want.st, want.data, want.last, st, d, lf));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] command;
    word_t      push_value;
    logic       result_valid;
    logic [1:0] status;
    word_t      data_value;
    logic       last_flag;

    cq_shadow shadow;
    bit       allow_gaps;
    int       idle_cycles;

    circular_queue #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .push_value(push_value),
        .result_valid(result_valid),
        .status(status),
        .data_value(data_value),
        .last_flag(last_flag)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result monitor, sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && result_valid)
            shadow.match_result(status, data_value, last_flag);
    end

    // Watchdog: cycles with no handshake on either side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one command word, hold it until taken, then log it
    task automatic send_word(input logic [1:0] cmd, input word_t val);
        bit taken;
        if (allow_gaps)
        begin
            while ($urandom_range(0, 99) < 35)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        command <= cmd;
        push_value <= val;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        shadow.log_command(cmd, val);
    endtask

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Random command with a bias that depends on the phase
    function automatic logic [1:0] pick_command(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return CMD_NONE;
        roll = $urandom_range(0, 99);
        case (phase)
            0: return (roll < 70) ? CMD_PUSH : (roll < 85) ? CMD_POP : CMD_DUMP;
            1: return (roll < 70) ? CMD_POP : (roll < 85) ? CMD_PUSH : CMD_DUMP;
            default: return (roll < 40) ? CMD_PUSH : (roll < 80) ? CMD_POP : CMD_DUMP;
        endcase
    endfunction

    initial
    begin
        int          counted;
        int          phase;
        logic [1:0]  cmd;
        shadow = new();
        idle_cycles = 0;
        allow_gaps = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_PUSH;
        push_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, fill to full, overflow, wrap, drain
        send_word(CMD_DUMP, 32'sh12345678);
        send_word(CMD_POP, 32'sh0);
        send_word(CMD_PUSH, 32'sh7FFFFFFF);
        send_word(CMD_PUSH, 32'sh80000000);
        send_word(CMD_PUSH, 32'sh0);
        send_word(CMD_PUSH, -32'sd1);
        send_word(CMD_PUSH, 32'sh55555555);
        send_word(CMD_PUSH, 32'shAAAAAAAA);
        send_word(CMD_PUSH, 32'sd1);
        send_word(CMD_PUSH, word_t'($urandom));
        send_word(CMD_PUSH, 32'sh0BADF00D);
        send_word(CMD_DUMP, 32'sh0);
        send_word(CMD_POP, 32'sh0);
        send_word(CMD_POP, 32'sh0);
        send_word(CMD_NONE, 32'sh7FFFFFFF);
        send_word(CMD_PUSH, 32'sd12345);
        send_word(CMD_PUSH, -32'sd2);
        send_word(CMD_DUMP, 32'sh0);
        repeat (RING_DEPTH) send_word(CMD_POP, word_t'($urandom));

        // Random: phases that fill, drain or mix, with a stretch of no gaps
        counted = 0;
        phase = 2;
        while (counted < RANDOM_WORDS)
        begin
            if (counted % 16 == 0)
                phase = $urandom_range(0, 2);
            allow_gaps = !(counted >= 50 && counted < 90);
            cmd = pick_command(phase);
            send_word(cmd, pick_value());
            if (cmd != CMD_NONE)
                counted++;
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (shadow.faults == 0 && shadow.due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* circular_queue.f */
rtl/core/cq_pkg.sv
rtl/core/cq_ram.sv
rtl/core/cq_cmd_fifo.sv
rtl/core/cq_front.sv
rtl/core/cq_back.sv
rtl/core/circular_queue.sv
tb/tb_top.sv
